// ===== design/bmp_pkg.sv =====
// Shared constants and types for the binomial mod prime block.
package bmp_pkg;

  localparam int          DEF_TABLE_SIZE = 4096;
  localparam int          COUNT_W        = 12;
  localparam int          VALUE_W        = 30;
  localparam logic [29:0] P_MOD          = 30'd1000000007;
  localparam logic [31:0] P_MOD_X2       = 32'd2000000014;
  localparam logic [29:0] FERMAT_EXP     = 30'd1000000005;
  // floor(2^61 / P_MOD)
  localparam logic [31:0] BARRETT_M      = 32'd2305842993;
  localparam logic [4:0]  EXP_LAST_BIT   = 5'd29;

  typedef enum logic [2:0] {
    BS_INIT,
    BS_FACT,
    BS_EXP,
    BS_INV,
    BS_DONE
  } build_state_t;

  typedef struct packed {
    logic fact_we;
    logic inv_we;
  } tbl_wr_t;

endpackage

// ===== design/binomial_mod_prime.sv =====
// Top level: C(n,r) mod 1000000007 query pipeline.
// After reset the block builds its factorial and inverse factorial tables, and
// query_ready stays low until then. Afterwards one query is taken every cycle
// while the result port is not stalled; each passes through the input register,
// table read, then two 4-stage modular multipliers (inverse product, then times
// the factorial) and the output register. A stall at the result port holds the
// whole pipeline. r > n gives 0 with r_exceeds_n set; n at or beyond TABLE_SIZE
// with r <= n gives 0 with the flag clear.
module binomial_mod_prime #(
  parameter int TABLE_SIZE = bmp_pkg::DEF_TABLE_SIZE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        query_valid,
  output logic                        query_ready,
  input  logic [bmp_pkg::COUNT_W-1:0] top_count,
  input  logic [bmp_pkg::COUNT_W-1:0] choose_count,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [bmp_pkg::VALUE_W-1:0] binomial_value,
  output logic                        r_exceeds_n
);
  import bmp_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);

  logic               built;
  tbl_wr_t            wr;
  logic [IW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic               adv;
  logic               v0, v1;
  logic [COUNT_W-1:0] n0, r0, nr0;
  logic               flag0, zero0, flag1, zero1;
  logic [VALUE_W-1:0] fact_n, inv_r, inv_nr;
  logic               va, vb;
  logic [VALUE_W-1:0] den, prod;
  logic [VALUE_W+1:0] tag_a;
  logic [1:0]         tag_b;

  assign adv         = !result_valid || result_ready;
  assign query_ready = adv && built;

  assign flag0 = r0 > n0;
  assign zero0 = flag0 || (32'(n0) >= TABLE_SIZE);
  assign nr0   = n0 - r0;

  bmp_build #(.TABLE_SIZE(TABLE_SIZE), .IW(IW)) u_build (
    .clk(clk), .rst(rst), .built(built), .wr(wr), .waddr(waddr), .wdata(wdata)
  );

  bmp_lookup #(.TABLE_SIZE(TABLE_SIZE), .IW(IW)) u_lookup (
    .clk(clk), .en(adv), .wr(wr), .waddr(waddr), .wdata(wdata),
    .addr_n(IW'(n0)), .addr_r(IW'(r0)), .addr_nr(IW'(nr0)),
    .fact_n(fact_n), .inv_r(inv_r), .inv_nr(inv_nr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (adv) begin
      v0 <= query_valid && built;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n0    <= top_count;
      r0    <= choose_count;
      flag1 <= flag0;
      zero1 <= zero0;
    end
  end

  bmp_mulmod #(.TW(VALUE_W + 2)) u_mul_den (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v1),
    .a(inv_r), .b(inv_nr), .tag_in({flag1, zero1, fact_n}),
    .out_valid(va), .res(den), .tag_out(tag_a)
  );

  bmp_mulmod #(.TW(2)) u_mul_num (
    .clk(clk), .rst(rst), .en(adv), .in_valid(va),
    .a(tag_a[VALUE_W-1:0]), .b(den), .tag_in(tag_a[VALUE_W+1:VALUE_W]),
    .out_valid(vb), .res(prod), .tag_out(tag_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      binomial_value <= tag_b[0] ? '0 : prod;
      r_exceeds_n    <= tag_b[1];
    end
  end

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && r_exceeds_n |-> binomial_value == '0)
    else $error("flagged result not zero");

  a_reduced: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> binomial_value < P_MOD)
    else $error("result not reduced");

  a_idle_build: assert property (@(posedge clk) disable iff (rst)
    !built |-> !result_valid && !v0 && !v1)
    else $error("pipeline active during table build");

endmodule

// ===== design/bmp_mulmod.sv =====
// Four-stage pipelined multiply modulo P_MOD with Barrett reduction.
module bmp_mulmod #(
  parameter int TW = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [bmp_pkg::VALUE_W-1:0] a,
  input  logic [bmp_pkg::VALUE_W-1:0] b,
  input  logic [TW-1:0]               tag_in,
  output logic                        out_valid,
  output logic [bmp_pkg::VALUE_W-1:0] res,
  output logic [TW-1:0]               tag_out
);
  import bmp_pkg::*;

  logic [3:0]    v;
  logic [59:0]   prod;
  logic [29:0]   quot;
  logic [31:0]   lo;
  logic [31:0]   rem;
  logic [TW-1:0] t1, t2, t3;
  logic [62:0]   qwide;
  logic [31:0]   rem_next;
  logic [29:0]   res_next;

  assign qwide    = 63'(prod[59:29]) * 63'(BARRETT_M);
  assign rem_next = lo - 32'(quot) * 32'(P_MOD);

  always_comb begin
    if (rem >= P_MOD_X2) begin
      res_next = 30'(rem - P_MOD_X2);
    end else if (rem >= 32'(P_MOD)) begin
      res_next = 30'(rem - 32'(P_MOD));
    end else begin
      res_next = 30'(rem);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod    <= 60'(a) * 60'(b);
      t1      <= tag_in;
      quot    <= qwide[61:32];
      lo      <= prod[31:0];
      t2      <= t1;
      rem     <= rem_next;
      t3      <= t2;
      res     <= res_next;
      tag_out <= t3;
    end
  end

  assign out_valid = v[3];

endmodule

// ===== design/bmp_build.sv =====
// Table builder: factorials upward, one Fermat inverse, inverse factorials downward.
module bmp_build #(
  parameter int TABLE_SIZE = bmp_pkg::DEF_TABLE_SIZE,
  parameter int IW         = $clog2(TABLE_SIZE)
) (
  input  logic                        clk,
  input  logic                        rst,
  output logic                        built,
  output bmp_pkg::tbl_wr_t            wr,
  output logic [IW-1:0]               waddr,
  output logic [bmp_pkg::VALUE_W-1:0] wdata
);
  import bmp_pkg::*;

  build_state_t  state, state_next;
  logic          pend, pend_next;
  logic          ph, ph_next;
  logic [IW-1:0] k, k_next;
  logic [29:0]   cur, cur_next;
  logic [29:0]   acc, acc_next;
  logic [29:0]   sq, sq_next;
  logic [4:0]    ebit, ebit_next;
  logic          mul_issue;
  logic [29:0]   mul_a, mul_b;
  logic          res_valid;
  logic [29:0]   res;
  logic          res_tag;

  localparam logic [IW-1:0] K_LAST = IW'(TABLE_SIZE - 1);
  localparam logic [IW-1:0] K_ONE  = IW'(1);

  bmp_mulmod #(.TW(1)) u_mul (
    .clk(clk), .rst(rst), .en(1'b1), .in_valid(mul_issue),
    .a(mul_a), .b(mul_b), .tag_in(ph),
    .out_valid(res_valid), .res(res), .tag_out(res_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_INIT;
      pend  <= 1'b0;
      ph    <= 1'b0;
      k     <= K_ONE;
      cur   <= 30'd1;
      acc   <= 30'd1;
      sq    <= 30'd1;
      ebit  <= '0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      ph    <= ph_next;
      k     <= k_next;
      cur   <= cur_next;
      acc   <= acc_next;
      sq    <= sq_next;
      ebit  <= ebit_next;
    end
  end

  always_comb begin
    state_next = state;
    pend_next  = pend;
    ph_next    = ph;
    k_next     = k;
    cur_next   = cur;
    acc_next   = acc;
    sq_next    = sq;
    ebit_next  = ebit;
    mul_issue  = 1'b0;
    mul_a      = cur;
    mul_b      = 30'(k);
    wr         = '0;
    waddr      = k;
    wdata      = res;
    built      = 1'b0;
    case (state)
      BS_INIT: begin
        wr.fact_we = 1'b1;
        waddr      = '0;
        wdata      = 30'd1;
        state_next = BS_FACT;
      end
      BS_FACT: begin
        if (!pend) begin
          mul_issue = 1'b1;
          pend_next = 1'b1;
        end else if (res_valid) begin
          wr.fact_we = 1'b1;
          cur_next   = res;
          pend_next  = 1'b0;
          if (k == K_LAST) begin
            sq_next    = res;
            acc_next   = 30'd1;
            ebit_next  = '0;
            ph_next    = 1'b0;
            state_next = BS_EXP;
          end else begin
            k_next = k + K_ONE;
          end
        end
      end
      BS_EXP: begin
        mul_a = ph ? sq : acc;
        mul_b = sq;
        if (!pend) begin
          mul_issue = 1'b1;
          pend_next = 1'b1;
        end else if (res_valid) begin
          pend_next = 1'b0;
          if (!res_tag) begin
            if (FERMAT_EXP[ebit]) begin
              acc_next = res;
            end
            ph_next = 1'b1;
          end else begin
            sq_next = res;
            ph_next = 1'b0;
            if (ebit == EXP_LAST_BIT) begin
              wr.inv_we  = 1'b1;
              waddr      = K_LAST;
              wdata      = acc;
              cur_next   = acc;
              k_next     = K_LAST;
              state_next = BS_INV;
            end else begin
              ebit_next = ebit + 5'd1;
            end
          end
        end
      end
      BS_INV: begin
        waddr = k - K_ONE;
        if (!pend) begin
          mul_issue = 1'b1;
          pend_next = 1'b1;
        end else if (res_valid) begin
          wr.inv_we = 1'b1;
          cur_next  = res;
          pend_next = 1'b0;
          if (k == K_ONE) begin
            state_next = BS_DONE;
          end else begin
            k_next = k - K_ONE;
          end
        end
      end
      BS_DONE: begin
        built = 1'b1;
      end
      default: begin
        state_next = BS_INIT;
      end
    endcase
  end

endmodule

// ===== design/bmp_lookup.sv =====
// Factorial and inverse factorial memories with registered read ports.
module bmp_lookup #(
  parameter int TABLE_SIZE = bmp_pkg::DEF_TABLE_SIZE,
  parameter int IW         = $clog2(TABLE_SIZE)
) (
  input  logic                        clk,
  input  logic                        en,
  input  bmp_pkg::tbl_wr_t            wr,
  input  logic [IW-1:0]               waddr,
  input  logic [bmp_pkg::VALUE_W-1:0] wdata,
  input  logic [IW-1:0]               addr_n,
  input  logic [IW-1:0]               addr_r,
  input  logic [IW-1:0]               addr_nr,
  output logic [bmp_pkg::VALUE_W-1:0] fact_n,
  output logic [bmp_pkg::VALUE_W-1:0] inv_r,
  output logic [bmp_pkg::VALUE_W-1:0] inv_nr
);
  import bmp_pkg::*;

  logic [VALUE_W-1:0] fact_mem [TABLE_SIZE];
  logic [VALUE_W-1:0] inv_mem  [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (wr.fact_we) begin
      fact_mem[waddr] <= wdata;
    end
    if (wr.inv_we) begin
      inv_mem[waddr] <= wdata;
    end
    if (en) begin
      fact_n <= fact_mem[addr_n];
      inv_r  <= inv_mem[addr_r];
      inv_nr <= inv_mem[addr_nr];
    end
  end

endmodule

// ===== sim/binomial_mod_prime_test.sv =====
// Testbench for binomial_mod_prime: random and directed C(n,r) queries checked against a local table model.
module binomial_mod_prime_test;
  import bmp_pkg::*;

  localparam int      TBL_N      = DEF_TABLE_SIZE;
  localparam longint  PRIME      = 64'd1000000007;
  localparam int      STALL_MAX  = 200000;

  typedef struct {
    logic [COUNT_W-1:0] n;
    logic [COUNT_W-1:0] r;
  } query_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               flag;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic query_valid = 1'b0;
  logic query_ready;
  logic [COUNT_W-1:0] top_count = '0;
  logic [COUNT_W-1:0] choose_count = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [VALUE_W-1:0] binomial_value;
  logic r_exceeds_n;

  binomial_mod_prime dut (.*);

  always #2 clk = ~clk;

  longint fact_tbl[TBL_N];
  longint inv_fact_tbl[TBL_N];
  query_t  pending_q[$];
  answer_t answers_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_mode = 0;
  int ready_cnt = 0;
  bit stim_done = 1'b0;
  bit in_taken = 1'b0;

  function automatic longint pow_mod(longint b, longint e);
    longint acc;
    acc = 1;
    b = b % PRIME;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) % PRIME;
      b = (b * b) % PRIME;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic answer_t binomial_of(query_t q);
    answer_t a;
    a.value = '0;
    a.flag = 1'b0;
    if (q.r > q.n) a.flag = 1'b1;
    else if (q.n < TBL_N)
      a.value = VALUE_W'((fact_tbl[q.n] *
                ((inv_fact_tbl[q.r] * inv_fact_tbl[q.n - q.r]) % PRIME)) % PRIME);
    return a;
  endfunction

  task automatic report(string what);
    errors++;
    $display("MISMATCH %s at %0t", what, $realtime);
  endtask

  task automatic add_query(int n, int r);
    query_t q;
    q.n = COUNT_W'(n);
    q.r = COUNT_W'(r);
    pending_q.push_back(q);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (query_valid && !in_taken) begin
      end else if (gap_left > 0 || pending_q.size() == 0) begin
        query_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        query_valid <= 1'b1;
        top_count <= pending_q[0].n;
        choose_count <= pending_q[0].r;
        void'(pending_q.pop_front());
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (ready_cnt == 0) begin
        ready_mode = $urandom_range(0, 3);
        ready_cnt = $urandom_range(5, 60);
      end
      ready_cnt--;
      case (ready_mode)
        0: result_ready <= 1'b1;
        1: result_ready <= $urandom_range(0, 1);
        2: result_ready <= ($urandom_range(0, 7) != 0);
        default: result_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t want;
    query_t q;
    in_taken = query_valid && query_ready;
    if (!rst) begin
      if (query_valid && query_ready) begin
        q.n = top_count;
        q.r = choose_count;
        answers_q.push_back(binomial_of(q));
      end
      if (result_valid && result_ready) begin
        if (answers_q.size() == 0) report("unexpected beat");
        else begin
          want = answers_q.pop_front();
          if (binomial_value !== want.value)
            report($sformatf("value got %0d want %0d", binomial_value, want.value));
          if (r_exceeds_n !== want.flag)
            report($sformatf("flag got %0b want %0b", r_exceeds_n, want.flag));
        end
      end
      if ((query_valid && query_ready) || (result_valid && result_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int n;
    fact_tbl[0] = 1;
    inv_fact_tbl[0] = 1;
    for (int k = 1; k < TBL_N; k++) begin
      fact_tbl[k] = (fact_tbl[k - 1] * k) % PRIME;
      inv_fact_tbl[k] = pow_mod(fact_tbl[k], PRIME - 2);
    end
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    add_query(0, 0);
    add_query(4095, 0);
    add_query(4095, 4095);
    add_query(4095, 2047);
    add_query(0, 4095);
    add_query(4094, 4095);
    add_query(1, 1);
    add_query(1, 0);
    add_query(10, 3);
    add_query(3, 10);
    add_query(2730, 1365);
    add_query(4095, 1);
    add_query(4095, 4094);
    add_query(100, 100);
    add_query(100, 101);
    add_query(2048, 1024);
    for (int i = 0; i < 550; i++) begin
      n = $urandom_range(0, 4095);
      case ($urandom_range(0, 4))
        0: add_query(n, $urandom_range(0, 4095));
        1: add_query(n, n);
        2: add_query(n, (n > 0) ? $urandom_range(0, 3) : 0);
        default: add_query(n, $urandom_range(0, n));
      endcase
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    wait (pending_q.size() == 0 && !query_valid);
    wait (answers_q.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && answers_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
